FILE: rtl/ctes_pkg.sv
// Shared types and constants for the civil time to epoch seconds converter.
// Depends on nothing; every other file imports it.
package ctes_pkg;

    // Field widths.
    localparam int YEAR_BITS = 16;
    localparam int CFG_BITS  = 16;
    localparam int OUT_BITS  = 41;
    localparam int TOD_BITS  = 19;   // time of day plus zone shift, signed

    localparam logic signed [CFG_BITS-1:0] FLOOR_RESET = 16'sd1970;

    // Era split: the shifted year u = y + ERA_OFFSET is never negative.
    // u/400 is computed as (u>>4)/25 with a reciprocal multiply.
    localparam int    U_BITS      = YEAR_BITS + 1;
    localparam int    N_BITS      = U_BITS - 4;
    localparam int    RECIP_SHIFT = N_BITS + 5;
    localparam int    RECIP_BITS  = N_BITS + 1;
    localparam int    PROD_BITS   = N_BITS + RECIP_BITS;
    localparam int    Q_BITS      = N_BITS - 4;
    localparam longint RECIP      = (longint'(1) << RECIP_SHIFT) / 25;
    localparam longint ERA_K      = ((longint'(1) << (YEAR_BITS - 1)) + 400) / 400;
    localparam longint ERA_OFFSET = ERA_K * 400;

    // Day count.
    localparam int    YOE_BITS     = 9;
    localparam int    DOY_BITS     = 10;  // signed, day zero gives -1
    localparam int    DOE_BITS     = 19;  // signed
    localparam int    EP_BITS      = Q_BITS + 18;
    localparam int    DAY_BITS     = EP_BITS + 2;
    localparam longint DAYS_PER_ERA = 146097;
    localparam longint DAY_BIAS     = ERA_K * DAYS_PER_ERA + 719468;

    // Seconds: 86400 = 675 * 128.
    localparam int    DAY_SCALE   = 675;
    localparam int    DAY_SHIFT   = 7;
    localparam int    SCALE_BITS  = DAY_BITS + 10;
    localparam int    SUM_BITS    = SCALE_BITS + DAY_SHIFT + 1;
    localparam longint OUT_MAX    = (longint'(1) << (OUT_BITS - 1)) - 1;
    localparam longint OUT_MIN    = -OUT_MAX - 1;

    // Result status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_FLOOR = 1'b1;

    typedef struct packed {
        logic signed [YEAR_BITS-1:0] year;
        logic [3:0]                  month;
        logic [4:0]                  day;
        logic [4:0]                  hour;
        logic [5:0]                  minute;
        logic [5:0]                  second;
        logic signed [11:0]          zone_offset;
        logic                        zone_given;
    } ctes_in_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] epoch_seconds;
        logic                       status;
    } ctes_out_t;

    // Day of the computing year at which a March-based month starts:
    // (153 * mp + 2) / 5.
    function automatic logic [8:0] doy_base(input logic [3:0] mp);
        logic [8:0] base;
        case (mp)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd92;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd153;
            4'd6:    base = 9'd184;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd245;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd306;
            4'd11:   base = 9'd337;
            4'd12:   base = 9'd367;
            4'd13:   base = 9'd398;
            4'd14:   base = 9'd428;
            default: base = 9'd459;
        endcase
        return base;
    endfunction

endpackage

FILE: rtl/civil_to_epoch_seconds.sv
// Top level of the civil time to epoch seconds converter: a seven-stage pipeline.
// Depends on ctes_pkg for the payload types, widths and the month table.
//
//   channel   direction   handshake              payload
//   s_        in          s_valid / s_ready      ctes_in_t  (one wall-clock reading)
//   m_        out         m_valid / m_ready      ctes_out_t (seconds and status)
//   cfg_      in          cfg_wr_en only         min_year, 16 bits signed
//
// One item enters per cycle while the output is free or taken. The accepting edge
// loads stage one; the item then moves through stages two to six into the output
// register, where m_valid rises. The depth is set by the divide-by-400 reciprocal
// multiply and the wide multiplies by 146097 and 675, each followed by a register.
// aresetn is synchronous and active low; it clears all valid bits and loads
// the earliest accepted year with 1970. When the output item is not taken, the
// whole pipeline holds and s_ready drops in the same cycle, so no item is
// dropped or repeated.
module civil_to_epoch_seconds (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  ctes_pkg::ctes_in_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output ctes_pkg::ctes_out_t                   m_data,
    input  logic                                  cfg_wr_en,
    input  logic signed [ctes_pkg::CFG_BITS-1:0]  cfg_wr_data
);
    import ctes_pkg::*;

    localparam int CMP_BITS = (YEAR_BITS > CFG_BITS) ? YEAR_BITS : CFG_BITS;

    // The pipeline moves as a whole whenever the output register is empty or being taken.
    logic advance;
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    // Configuration register.
    logic signed [CFG_BITS-1:0] min_year_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_year_reg <= FLOOR_RESET;
        end else if (cfg_wr_en) begin
            min_year_reg <= cfg_wr_data;
        end
    end

    // Valid bits of stages one to six; stage seven is m_valid itself.
    logic [5:0] valid_reg;
    logic       m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg   <= {valid_reg[4:0], s_valid};
            m_valid_reg <= valid_reg[5];
        end
    end
    assign m_valid = m_valid_reg;

    // Stage 1: floor check, computing-year shift, month index, time of day.
    logic                          fail1_reg, fail1_next;
    logic [U_BITS-1:0]             u1_reg, u1_next;
    logic [3:0]                    mp1_reg, mp1_next;
    logic [4:0]                    day1_reg;
    logic signed [TOD_BITS-1:0]    tod1_reg, tod1_next;

    logic signed [CMP_BITS-1:0]    year_cmp;
    logic signed [CMP_BITS-1:0]    floor_cmp;
    logic                          early_month;
    logic signed [YEAR_BITS+1:0]   year_shift;
    logic signed [TOD_BITS-1:0]    zone_secs;

    always_comb begin
        year_cmp    = CMP_BITS'(s_data.year);
        floor_cmp   = CMP_BITS'(min_year_reg);
        fail1_next  = (year_cmp < floor_cmp);
        // January, February and the unchecked month zero belong to the
        // computing year that started the March before.
        early_month = (s_data.month <= 4'd2);
        year_shift  = (YEAR_BITS+2)'(s_data.year) - (YEAR_BITS+2)'(early_month)
                      + (YEAR_BITS+2)'(ERA_OFFSET);
        u1_next     = year_shift[U_BITS-1:0];
        mp1_next    = early_month ? (s_data.month + 4'd9) : (s_data.month - 4'd3);
        zone_secs   = s_data.zone_given
                      ? TOD_BITS'(s_data.zone_offset) * TOD_BITS'(60) : '0;
        tod1_next   = TOD_BITS'(s_data.hour) * TOD_BITS'(3600)
                      + TOD_BITS'(s_data.minute) * TOD_BITS'(60)
                      + TOD_BITS'(s_data.second) + zone_secs;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fail1_reg <= fail1_next;
            u1_reg    <= u1_next;
            mp1_reg   <= mp1_next;
            day1_reg  <= s_data.day;
            tod1_reg  <= tod1_next;
        end
    end

    // Stage 2: reciprocal multiply for u/400 and the day of the computing year.
    logic                          fail2_reg;
    logic [PROD_BITS-1:0]          prod2_reg, prod2_next;
    logic [N_BITS-1:0]             n2_reg;
    logic [3:0]                    low2_reg;
    logic signed [DOY_BITS-1:0]    doy2_reg, doy2_next;
    logic signed [TOD_BITS-1:0]    tod2_reg;

    always_comb begin
        prod2_next = PROD_BITS'(u1_reg[U_BITS-1:4]) * PROD_BITS'(RECIP);
        doy2_next  = $signed({1'b0, doy_base(mp1_reg)}) + $signed({5'b0, day1_reg})
                     - DOY_BITS'(1);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fail2_reg <= fail1_reg;
            prod2_reg <= prod2_next;
            n2_reg    <= u1_reg[U_BITS-1:4];
            low2_reg  <= u1_reg[3:0];
            doy2_reg  <= doy2_next;
            tod2_reg  <= tod1_reg;
        end
    end

    // Stage 3: the quotient estimate is exact or one short; fix it and form
    // the year of the era.
    logic                          fail3_reg;
    logic [Q_BITS-1:0]             q3_reg, q3_next;
    logic [YOE_BITS-1:0]           yoe3_reg, yoe3_next;
    logic signed [DOY_BITS-1:0]    doy3_reg;
    logic signed [TOD_BITS-1:0]    tod3_reg;

    logic [Q_BITS-1:0]             q_est;
    logic [N_BITS-1:0]             rem_full;
    logic [5:0]                    rem;
    logic [4:0]                    rem_fixed;

    always_comb begin
        q_est    = prod2_reg[PROD_BITS-1:RECIP_SHIFT];
        rem_full = n2_reg - N_BITS'(q_est) * N_BITS'(25);
        rem      = rem_full[5:0];
        if (rem >= 6'd25) begin
            q3_next   = q_est + Q_BITS'(1);
            rem_fixed = 5'(rem - 6'd25);
        end else begin
            q3_next   = q_est;
            rem_fixed = rem[4:0];
        end
        yoe3_next = {rem_fixed, low2_reg};
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fail3_reg <= fail2_reg;
            q3_reg    <= q3_next;
            yoe3_reg  <= yoe3_next;
            doy3_reg  <= doy2_reg;
            tod3_reg  <= tod2_reg;
        end
    end

    // Stage 4: days of the whole eras and the day of the era.
    logic                          fail4_reg;
    logic [EP_BITS-1:0]            eprod4_reg, eprod4_next;
    logic signed [DOE_BITS-1:0]    doe4_reg, doe4_next;
    logic signed [TOD_BITS-1:0]    tod4_reg;

    logic [14:0]                   yoe_x41;
    logic [17:0]                   doe_base;

    always_comb begin
        eprod4_next = EP_BITS'(q3_reg) * EP_BITS'(DAYS_PER_ERA);
        // yoe/100 as (yoe*41)>>12, exact for yoe below 400.
        yoe_x41     = 15'(yoe3_reg) * 15'(41);
        doe_base    = 18'(yoe3_reg) * 18'(365) + 18'(yoe3_reg[YOE_BITS-1:2])
                      - 18'(yoe_x41[14:12]);
        doe4_next   = $signed({1'b0, doe_base}) + DOE_BITS'(doy3_reg);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fail4_reg  <= fail3_reg;
            eprod4_reg <= eprod4_next;
            doe4_reg   <= doe4_next;
            tod4_reg   <= tod3_reg;
        end
    end

    // Stage 5: days since the epoch, removing the era offset and epoch shift.
    logic                          fail5_reg;
    logic signed [DAY_BITS-1:0]    days5_reg, days5_next;
    logic signed [TOD_BITS-1:0]    tod5_reg;

    always_comb begin
        days5_next = $signed({2'b0, eprod4_reg}) + DAY_BITS'(doe4_reg)
                     - DAY_BITS'(DAY_BIAS);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fail5_reg <= fail4_reg;
            days5_reg <= days5_next;
            tod5_reg  <= tod4_reg;
        end
    end

    // Stage 6: days times 675; the factor 128 is a shift in the next stage.
    logic                          fail6_reg;
    logic signed [SCALE_BITS-1:0]  scaled6_reg, scaled6_next;
    logic signed [TOD_BITS-1:0]    tod6_reg;

    always_comb begin
        scaled6_next = SCALE_BITS'(days5_reg) * SCALE_BITS'(DAY_SCALE);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fail6_reg   <= fail5_reg;
            scaled6_reg <= scaled6_next;
            tod6_reg    <= tod5_reg;
        end
    end

    // Stage 7: add the time of day, saturate to 41 bits, apply the floor check.
    ctes_out_t                     out_reg, out_next;
    logic signed [SUM_BITS-1:0]    sum;
    logic signed [SUM_BITS-1:0]    sat;

    always_comb begin
        sum = (SUM_BITS'(scaled6_reg) <<< DAY_SHIFT) + SUM_BITS'(tod6_reg);
        if (sum > SUM_BITS'(OUT_MAX)) begin
            sat = SUM_BITS'(OUT_MAX);
        end else if (sum < SUM_BITS'(OUT_MIN)) begin
            sat = SUM_BITS'(OUT_MIN);
        end else begin
            sat = sum;
        end
        if (fail6_reg) begin
            out_next.epoch_seconds = '0;
            out_next.status        = STATUS_FLOOR;
        end else begin
            out_next.epoch_seconds = sat[OUT_BITS-1:0];
            out_next.status        = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end
    assign m_data = out_reg;

endmodule

FILE: rtl/ctes_checker.sv
// Port-level checks for civil_to_epoch_seconds, attached by the bind at the end.
// Depends on ctes_pkg for the payload types.
module ctes_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input ctes_pkg::ctes_out_t                   m_data
);
    import ctes_pkg::*;

    // A refused reading always carries zero seconds.
    assert property (@(posedge aclk)
        (m_valid && m_data.status == STATUS_FLOOR) |-> (m_data.epoch_seconds == '0))
        else $error("floor failure with nonzero seconds");

    // With the output always taken, an accepted item must come out of the pipeline.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
        ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("item did not emerge after the pipeline depth");

    // An empty output register never blocks the input.
    assert property (@(posedge aclk) !m_valid |-> s_ready)
        else $error("input stalled while output empty");

    // Reset empties the pipeline.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind civil_to_epoch_seconds ctes_checker u_ctes_checker (.*);

FILE: sim/civil_to_epoch_seconds_tb.sv
// Self-checking testbench for the civil time to epoch seconds converter.
// Depends on ctes_pkg for the payload structs, widths and status codes, and on
// the civil_to_epoch_seconds RTL; it predicts every result in its own code.
module civil_to_epoch_seconds_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctes_pkg::*;

    // The pipeline is seven stages deep; this margin covers it with room to spare.
    localparam int DRAIN_CYCLES = 12;
    // The receiver goes deaf once, after this many results; the second value sets how long.
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 150;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    ctes_in_t                     s_data      = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    ctes_out_t                    m_data;
    logic                         cfg_wr_en   = 1'b0;
    logic signed [CFG_BITS-1:0]   cfg_wr_data = '0;

    // Readings waiting to be offered, and results the converter still owes us.
    ctes_in_t  pending_readings[$];
    ctes_out_t expected_results[$];

    // Our copy of the floor year; it only changes while the converter is idle.
    longint min_year_model = 1970;

    bit idle_enable     = 1'b0;
    int send_gap        = 0;
    int recv_gap        = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;
    int results_seen    = 0;
    int floor_refusals  = 0;
    int floor_settings  = 1;
    int error_count     = 0;

    civil_to_epoch_seconds dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Hard limit on the run. The slowest legal run (every item waiting out the
    // longest sender gap and the longest receiver stall, plus the one long hold)
    // stays under a tenth of this.
    initial begin
        #20ms;
        $display("Timeout: converter stopped making progress");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Gap lengths: mostly back to back, often a few cycles, now and then a long pause.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        if (roll < 98)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Day number relative to 1970-01-01 with March as the first month of the
    // computing year and 400-year eras. Divisions truncate toward zero, so the
    // era of a negative year is biased by 399 first to get a floor divide.
    function automatic longint civil_day_number(longint yr, longint mon, longint dom);
        longint era;
        longint yoe;
        longint mar_month;
        longint doy;
        longint doe;
        if (mon <= 2)
            yr = yr - 1;
        era = ((yr >= 0) ? yr : yr - 399) / 400;
        yoe = yr - era * 400;
        mar_month = (mon > 2) ? mon - 3 : mon + 9;
        doy = (153 * mar_month + 2) / 5 + dom - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    // Expected converter output for one reading under the given floor year.
    function automatic ctes_out_t epoch_of_reading(ctes_in_t rd, longint floor_yr);
        ctes_out_t res;
        longint    yr;
        longint    secs;
        longint    secs_max;
        longint    secs_min;
        secs_max = (longint'(1) << (OUT_BITS - 1)) - 1;
        secs_min = -secs_max - 1;
        yr = longint'(signed'(rd.year));
        if (yr < floor_yr) begin
            res.epoch_seconds = '0;
            res.status        = STATUS_FLOOR;
            return res;
        end
        secs = civil_day_number(yr, longint'(rd.month), longint'(rd.day)) * 86400
             + longint'(rd.hour) * 3600 + longint'(rd.minute) * 60 + longint'(rd.second);
        if (rd.zone_given)
            secs = secs + longint'(signed'(rd.zone_offset)) * 60;
        if (secs > secs_max)
            secs = secs_max;
        if (secs < secs_min)
            secs = secs_min;
        res.epoch_seconds = secs[OUT_BITS-1:0];
        res.status        = STATUS_OK;
        return res;
    endfunction

    function automatic ctes_in_t make_reading(int yr, int mon, int dom, int hr, int mnt,
                                              int sec, int zone, bit zone_on);
        ctes_in_t rd;
        rd.year        = yr[YEAR_BITS-1:0];
        rd.month       = mon[3:0];
        rd.day         = dom[4:0];
        rd.hour        = hr[4:0];
        rd.minute      = mnt[5:0];
        rd.second      = sec[5:0];
        rd.zone_offset = zone[11:0];
        rd.zone_given  = zone_on;
        return rd;
    endfunction

    // Random reading. Years cluster around the floor so both sides of the
    // comparison are hit often; the rest spread over modern dates and the whole
    // 16-bit range. Most fields stay legal, some take any value their width allows.
    function automatic ctes_in_t random_reading();
        ctes_in_t rd;
        int       roll;
        longint   yr;
        roll = $urandom_range(99);
        if (roll < 40) begin
            yr = min_year_model + $urandom_range(40) - 20;
            if (yr < -32768)
                yr = -32768;
            if (yr > 32767)
                yr = 32767;
        end else if (roll < 70) begin
            yr = $urandom_range(2100, 1900);
        end else begin
            yr = longint'(signed'(16'($urandom())));
        end
        rd.year        = yr[YEAR_BITS-1:0];
        rd.month       = ($urandom_range(99) < 85) ? 4'($urandom_range(12, 1)) : 4'($urandom());
        rd.day         = ($urandom_range(99) < 85) ? 5'($urandom_range(31, 1)) : 5'($urandom());
        rd.hour        = ($urandom_range(99) < 85) ? 5'($urandom_range(23)) : 5'($urandom());
        rd.minute      = ($urandom_range(99) < 85) ? 6'($urandom_range(59)) : 6'($urandom());
        rd.second      = ($urandom_range(99) < 85) ? 6'($urandom_range(59)) : 6'($urandom());
        rd.zone_offset = ($urandom_range(99) < 80) ? 12'(int'($urandom_range(2880)) - 1440)
                                                   : 12'($urandom());
        rd.zone_given  = 1'($urandom());
        return rd;
    endfunction

    // Sender. The payload is only replaced once the current item is taken, and
    // each accepted item gets its expected result predicted right away, using
    // the floor year in force while it is in flight.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(epoch_of_reading(s_data, min_year_model));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    s_valid <= 1'b0;
                    send_gap = send_gap - 1;
                end else if (pending_readings.size() != 0) begin
                    s_data  <= pending_readings.pop_front();
                    s_valid <= 1'b1;
                    send_gap = idle_enable ? pick_gap() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker. Each result is matched against the oldest prediction.
    // After HOLD_AFTER results the receiver holds m_ready low once while
    // the sender keeps offering items, so the pipeline fills and s_ready drops.
    always @(posedge aclk) begin
        ctes_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen = results_seen + 1;
                if (expected_results.size() == 0) begin
                    error_count = error_count + 1;
                    $display("%0t: unexpected result, epoch_seconds %0d status %0b",
                             $time, m_data.epoch_seconds, m_data.status);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.epoch_seconds !== want.epoch_seconds) begin
                        error_count = error_count + 1;
                        $display("%0t: epoch_seconds mismatch, expected %0d, got %0d",
                                 $time, want.epoch_seconds, m_data.epoch_seconds);
                    end
                    if (m_data.status !== want.status) begin
                        error_count = error_count + 1;
                        $display("%0t: status mismatch, expected %0b, got %0b",
                                 $time, want.status, m_data.status);
                    end
                    if (want.status == STATUS_FLOOR)
                        floor_refusals = floor_refusals + 1;
                end
            end
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (recv_gap > 0) begin
                m_ready <= 1'b0;
                recv_gap = recv_gap - 1;
            end else begin
                m_ready <= 1'b1;
                recv_gap = idle_enable ? pick_gap() : 0;
            end
        end
    end

    // Waits until every reading has been taken and every result has come back,
    // then lets the pipeline settle before anything else happens.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pending_readings.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Only called while the converter is idle.
    task automatic write_floor(longint new_floor);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= new_floor[CFG_BITS-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        min_year_model = longint'(signed'(new_floor[CFG_BITS-1:0]));
        floor_settings = floor_settings + 1;
    endtask

    task automatic queue_random(int count);
        @(negedge aclk);
        repeat (count) pending_readings.push_back(random_reading());
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Floor at its reset value of 1970: the years on each side of it.
        pending_readings.push_back(make_reading(1969, 12, 31, 23, 59, 59, 0, 1'b0));
        pending_readings.push_back(make_reading(1970, 1, 1, 0, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(-32768, 1, 1, 0, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(32767, 12, 31, 23, 59, 59, 0, 1'b0));
        wait_idle();

        // Lowest floor, so every directed reading converts.
        write_floor(-32768);
        @(negedge aclk);
        // Epoch itself, leap days, century rules and negative era boundaries.
        pending_readings.push_back(make_reading(1970, 1, 1, 0, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(2000, 2, 29, 12, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(1900, 3, 1, 0, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(0, 3, 1, 0, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(-1, 12, 31, 0, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(-400, 1, 1, 0, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(-401, 2, 28, 0, 0, 0, 0, 1'b0));
        // Month zero and months past twelve follow the March-based table.
        pending_readings.push_back(make_reading(2024, 0, 15, 0, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(2024, 13, 1, 0, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(2024, 14, 10, 0, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(2024, 15, 31, 0, 0, 0, 0, 1'b0));
        // Day zero is the day before the first; overlarge time fields just add on.
        pending_readings.push_back(make_reading(2024, 6, 0, 0, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(2024, 1, 31, 0, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(2024, 6, 15, 31, 63, 63, 0, 1'b0));
        // Zone offset across its whole 12-bit range, and ignored when not given.
        pending_readings.push_back(make_reading(2024, 6, 15, 12, 30, 0, -2048, 1'b1));
        pending_readings.push_back(make_reading(2024, 6, 15, 12, 30, 0, 2047, 1'b1));
        pending_readings.push_back(make_reading(2024, 6, 15, 12, 30, 0, 1440, 1'b1));
        pending_readings.push_back(make_reading(2024, 6, 15, 12, 30, 0, -1440, 1'b1));
        pending_readings.push_back(make_reading(2024, 6, 15, 12, 30, 0, 2047, 1'b0));
        // Every field but the zone offset at its lowest and at its highest encoding.
        pending_readings.push_back(make_reading(-32768, 0, 0, 0, 0, 0, 0, 1'b0));
        pending_readings.push_back(make_reading(32767, 15, 31, 31, 63, 63, -2048, 1'b1));
        wait_idle();

        // Highest floor: only the very last year gets through.
        write_floor(32767);
        @(negedge aclk);
        pending_readings.push_back(make_reading(32766, 12, 31, 23, 59, 59, 0, 1'b0));
        pending_readings.push_back(make_reading(32767, 1, 1, 0, 0, 0, 0, 1'b0));
        wait_idle();

        // Random floor, both sides running flat out with no idling.
        write_floor(longint'(signed'(16'($urandom()))));
        queue_random(200);
        wait_idle();

        // Floor back at 1970 with random idling. The long receiver hold falls in
        // the first half; between halves the sender stops until all results are in.
        write_floor(1970);
        idle_enable = 1'b1;
        queue_random(250);
        wait_idle();
        queue_random(250);
        wait_idle();

        write_floor(32767);
        queue_random(50);
        wait_idle();

        write_floor(0);
        queue_random(150);
        wait_idle();

        if (expected_results.size() != 0) begin
            error_count = error_count + 1;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end
        $display("Checked %0d converted readings under %0d floor-year settings;",
                 results_seen, floor_settings);
        $display("%0d of them were refused as older than the floor year.", floor_refusals);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
